// ----- design/wcsp_pkg.sv -----
// Package for the code stream parser: beat types, codes, parse modes and opcode tables.
`timescale 1ns / 1ps
`default_nettype none
package wcsp_pkg;

    localparam int MAX_DEPTH_DEFAULT = 32;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  opcode_out;
        logic [3:0]  imm_kind;
        logic [63:0] immediate;
        logic [31:0] mem_offset;
        logic [5:0]  nest_depth;
        logic [2:0]  error_code;
        logic        expr_end;
    } out_beat_t;

    typedef enum logic [3:0] {
        MODE_OPCODE   = 4'd0,
        MODE_INDEX    = 4'd1,
        MODE_CI_IDX   = 4'd2,
        MODE_CI_RES   = 4'd3,
        MODE_MEM_RES  = 4'd4,
        MODE_ALIGN    = 4'd5,
        MODE_OFFSET   = 4'd6,
        MODE_I32      = 4'd7,
        MODE_I64      = 4'd8,
        MODE_F32      = 4'd9,
        MODE_F64      = 4'd10,
        MODE_BTYPE    = 4'd11,
        MODE_TCOUNT   = 4'd12,
        MODE_TLABEL   = 4'd13,
        MODE_TDEFAULT = 4'd14
    } mode_t;

    typedef enum logic [1:0] {
        LEB_MORE = 2'd0,
        LEB_DONE = 2'd1,
        LEB_BAD  = 2'd2
    } leb_status_t;

    localparam logic [3:0] KIND_NONE     = 4'd0;
    localparam logic [3:0] KIND_INDEX    = 4'd1;
    localparam logic [3:0] KIND_MEMARG   = 4'd2;
    localparam logic [3:0] KIND_I32      = 4'd3;
    localparam logic [3:0] KIND_I64      = 4'd4;
    localparam logic [3:0] KIND_F32      = 4'd5;
    localparam logic [3:0] KIND_F64      = 4'd6;
    localparam logic [3:0] KIND_BTYPE    = 4'd7;
    localparam logic [3:0] KIND_TLABEL   = 4'd8;
    localparam logic [3:0] KIND_TDEFAULT = 4'd9;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_OPCODE    = 3'd1;
    localparam logic [2:0] ERR_VALTYPE   = 3'd2;
    localparam logic [2:0] ERR_LEB       = 3'd3;
    localparam logic [2:0] ERR_RESERVED  = 3'd4;
    localparam logic [2:0] ERR_DEPTH     = 3'd5;

    localparam logic [1:0] LVL_IF   = 2'd2;
    localparam logic [1:0] LVL_ELSE = 2'd3;

    localparam logic [7:0] OP_ELSE = 8'h05;
    localparam logic [7:0] OP_END  = 8'h0B;
    localparam logic [7:0] BT_EMPTY = 8'h40;
    localparam logic [7:0] BT_F64   = 8'h7C;
    localparam logic [7:0] BT_I32   = 8'h7F;

    // Opcodes that carry no immediate and end with the opcode byte itself.
    function automatic logic op_plain(input logic [7:0] b);
        return (b == 8'h00) || (b == 8'h01) || (b == 8'h0F) || (b == 8'h1A) ||
               (b == 8'h1B) || (b >= 8'h45 && b <= 8'hBF) || (b == OP_END);
    endfunction

    // Mode that follows an opcode byte with an immediate; MODE_OPCODE otherwise.
    function automatic mode_t op_mode(input logic [7:0] b);
        mode_t m;
        m = MODE_OPCODE;
        if (b >= 8'h02 && b <= 8'h04) m = MODE_BTYPE;
        else if (b == 8'h0C || b == 8'h0D || b == 8'h10 || (b >= 8'h20 && b <= 8'h24))
            m = MODE_INDEX;
        else if (b == 8'h0E) m = MODE_TCOUNT;
        else if (b == 8'h11) m = MODE_CI_IDX;
        else if (b >= 8'h28 && b <= 8'h3E) m = MODE_ALIGN;
        else if (b == 8'h3F || b == 8'h40) m = MODE_MEM_RES;
        else if (b == 8'h41) m = MODE_I32;
        else if (b == 8'h42) m = MODE_I64;
        else if (b == 8'h43) m = MODE_F32;
        else if (b == 8'h44) m = MODE_F64;
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- design/wcsp_leb_unit.sv -----
// One LEB128 byte step: accumulate, length and padding checks, sign extension.
`timescale 1ns / 1ps
`default_nettype none
module wcsp_leb_unit (
    input  wire logic [7:0]          in_byte,
    input  wire logic [3:0]          leb_bytes,
    input  wire logic [63:0]         accum,
    input  wire logic                is_signed,
    input  wire logic                is64,
    output wcsp_pkg::leb_status_t    status,
    output logic      [63:0]         accum_next,
    output logic      [3:0]          bytes_next
);

    logic [6:0]  payload;
    logic [6:0]  shift;
    logic [6:0]  shift_up;
    logic [3:0]  nmax;
    logic        last;
    logic        pad_bad;
    logic [63:0] merged;

    always_comb begin
        payload  = in_byte[6:0];
        nmax     = is64 ? 4'd10 : 4'd5;
        shift    = {leb_bytes, 3'b000} - {3'b000, leb_bytes};
        shift_up = shift + 7'd7;
        last     = (leb_bytes == nmax - 4'd1);
        merged   = accum | ({57'd0, payload} << shift);
        if (is64)
            pad_bad = (payload != 7'h00) && (payload != 7'h7F);
        else if (is_signed)
            pad_bad = (payload[6:3] != 4'h0) && (payload[6:3] != 4'hF);
        else
            pad_bad = (payload[6:4] != 3'd0);
        bytes_next = leb_bytes;
        accum_next = merged;
        status     = wcsp_pkg::LEB_DONE;
        if (leb_bytes >= nmax) begin
            status = wcsp_pkg::LEB_BAD;
        end else if (last && (in_byte[7] || pad_bad)) begin
            status = wcsp_pkg::LEB_BAD;
        end else if (!last && in_byte[7]) begin
            status     = wcsp_pkg::LEB_MORE;
            bytes_next = leb_bytes + 4'd1;
        end else begin
            if (is_signed && shift_up < 7'd64 && in_byte[6])
                accum_next = merged | ({64{1'b1}} << shift_up);
            if (!is64)
                accum_next = {32'd0, accum_next[31:0]};
        end
    end

endmodule
`default_nettype wire

// ----- design/wcsp_level_stack.sv -----
// Nesting level memory with registered read and same-address write forwarding.
`timescale 1ns / 1ps
`default_nettype none
module wcsp_level_stack #(
    parameter int MAX_DEPTH = wcsp_pkg::MAX_DEPTH_DEFAULT,
    parameter int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [1:0]    wr_kind,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [1:0]    rd_kind
);

    logic [1:0] mem [MAX_DEPTH];
    logic [1:0] rd_kind_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_kind;
        end
        if (wr_en && wr_addr == rd_addr) begin
            rd_kind_reg <= wr_kind;
        end else begin
            rd_kind_reg <= mem[rd_addr];
        end
    end

    assign rd_kind = rd_kind_reg;

endmodule
`default_nettype wire

// ----- design/wasm_code_stream_parser.sv -----
// Top level of the byte-serial code body parser with output register.
// A token's result appears in the cycle after the beat that finishes it.
// Throughput: one byte beat per cycle while s_ready is high; the level memory
// read is registered at the next stack top, and a same-cycle write is forwarded.
// Reset (aresetn low, synchronous) empties the output register, the parse state
// and the depth; level memory contents stay undefined and are never read unwritten.
`timescale 1ns / 1ps
`default_nettype none
module wasm_code_stream_parser #(
    parameter int MAX_DEPTH = wcsp_pkg::MAX_DEPTH_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire wcsp_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output wcsp_pkg::out_beat_t      m_data
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // Parse state registers.
    wcsp_pkg::mode_t mode_reg, mode_next;
    logic [63:0]     accum_reg, accum_next;
    logic [3:0]      leb_bytes_reg, leb_bytes_next;
    logic [2:0]      raw_cnt_reg, raw_cnt_next;
    logic [7:0]      pending_reg, pending_next;
    logic [31:0]     align_reg, align_next;
    logic [31:0]     labels_reg, labels_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic            err_reg, err_next;

    logic                m_valid_reg;
    wcsp_pkg::out_beat_t m_data_reg;

    // The state that this beat sees: restart folds the reset values in first.
    wcsp_pkg::mode_t cur_mode;
    logic [63:0]     cur_accum;
    logic [3:0]      cur_bytes;
    logic [2:0]      cur_raw;
    logic [7:0]      cur_pending;
    logic [31:0]     cur_align;
    logic [31:0]     cur_labels;
    logic [DW-1:0]   cur_depth;
    logic            cur_err;

    logic                  accept;
    logic [7:0]            b;
    wcsp_pkg::leb_status_t leb_status;
    logic [63:0]           leb_accum;
    logic [3:0]            leb_bytes_out;
    logic                  leb_signed;
    logic                  leb_64;
    logic [1:0]            top_kind;
    logic                  else_ok;
    logic                  btype_ok;
    logic [31:0]           labels_dec;
    logic [2:0]            raw_last;

    logic                  emit;
    wcsp_pkg::out_beat_t   res;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [1:0]            wr_kind;
    logic [AW-1:0]         rd_addr;
    logic [DW-1:0]         depth_after;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign b       = s_data.in_byte;

    always_comb begin
        if (s_data.restart) begin
            cur_mode    = wcsp_pkg::MODE_OPCODE;
            cur_accum   = 64'd0;
            cur_bytes   = 4'd0;
            cur_raw     = 3'd0;
            cur_pending = 8'd0;
            cur_align   = 32'd0;
            cur_labels  = 32'd0;
            cur_depth   = '0;
            cur_err     = 1'b0;
        end else begin
            cur_mode    = mode_reg;
            cur_accum   = accum_reg;
            cur_bytes   = leb_bytes_reg;
            cur_raw     = raw_cnt_reg;
            cur_pending = pending_reg;
            cur_align   = align_reg;
            cur_labels  = labels_reg;
            cur_depth   = depth_reg;
            cur_err     = err_reg;
        end
    end

    assign leb_signed = (cur_mode == wcsp_pkg::MODE_I32) || (cur_mode == wcsp_pkg::MODE_I64);
    assign leb_64     = (cur_mode == wcsp_pkg::MODE_I64);

    wcsp_leb_unit u_leb (
        .in_byte    (b),
        .leb_bytes  (cur_bytes),
        .accum      (cur_accum),
        .is_signed  (leb_signed),
        .is64       (leb_64),
        .status     (leb_status),
        .accum_next (leb_accum),
        .bytes_next (leb_bytes_out)
    );

    wcsp_level_stack #(
        .MAX_DEPTH (MAX_DEPTH),
        .AW        (AW)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_kind (wr_kind),
        .rd_addr (rd_addr),
        .rd_kind (top_kind)
    );

    // The stack memory already holds the kind of the innermost level here,
    // since its read address followed the depth at the previous beat.
    assign else_ok    = (cur_depth != '0) && (top_kind == wcsp_pkg::LVL_IF);
    assign btype_ok   = (b == wcsp_pkg::BT_EMPTY) ||
                        (b >= wcsp_pkg::BT_F64 && b <= wcsp_pkg::BT_I32);
    assign labels_dec = cur_labels - 32'd1;
    assign raw_last   = (cur_mode == wcsp_pkg::MODE_F32) ? 3'd3 : 3'd7;

    // Next parse mode.
    always_comb begin
        mode_next = cur_mode;
        if (!cur_err) begin
            case (cur_mode)
                wcsp_pkg::MODE_OPCODE: begin
                    mode_next = wcsp_pkg::op_mode(b);
                end
                wcsp_pkg::MODE_INDEX, wcsp_pkg::MODE_CI_IDX, wcsp_pkg::MODE_ALIGN,
                wcsp_pkg::MODE_OFFSET, wcsp_pkg::MODE_TCOUNT, wcsp_pkg::MODE_TLABEL,
                wcsp_pkg::MODE_TDEFAULT, wcsp_pkg::MODE_I32, wcsp_pkg::MODE_I64: begin
                    if (leb_status == wcsp_pkg::LEB_BAD) begin
                        mode_next = wcsp_pkg::MODE_OPCODE;
                    end else if (leb_status == wcsp_pkg::LEB_DONE) begin
                        case (cur_mode)
                            wcsp_pkg::MODE_CI_IDX: mode_next = wcsp_pkg::MODE_CI_RES;
                            wcsp_pkg::MODE_ALIGN:  mode_next = wcsp_pkg::MODE_OFFSET;
                            wcsp_pkg::MODE_TCOUNT: begin
                                mode_next = (leb_accum[31:0] != 32'd0) ?
                                            wcsp_pkg::MODE_TLABEL : wcsp_pkg::MODE_TDEFAULT;
                            end
                            wcsp_pkg::MODE_TLABEL: begin
                                mode_next = (labels_dec != 32'd0) ?
                                            wcsp_pkg::MODE_TLABEL : wcsp_pkg::MODE_TDEFAULT;
                            end
                            default: mode_next = wcsp_pkg::MODE_OPCODE;
                        endcase
                    end
                end
                wcsp_pkg::MODE_F32, wcsp_pkg::MODE_F64: begin
                    if (cur_raw >= raw_last) mode_next = wcsp_pkg::MODE_OPCODE;
                end
                default: mode_next = wcsp_pkg::MODE_OPCODE;
            endcase
        end
    end

    // Datapath, result and stack accesses.
    always_comb begin
        accum_next     = cur_accum;
        leb_bytes_next = cur_bytes;
        raw_cnt_next   = cur_raw;
        pending_next   = cur_pending;
        align_next     = cur_align;
        labels_next    = cur_labels;
        depth_after    = cur_depth;
        err_next       = cur_err;
        emit           = 1'b0;
        res            = '0;
        wr_en          = 1'b0;
        wr_addr        = AW'(cur_depth);
        wr_kind        = wcsp_pkg::LVL_ELSE;
        if (!cur_err) begin
            case (cur_mode)
                wcsp_pkg::MODE_OPCODE: begin
                    pending_next   = b;
                    accum_next     = 64'd0;
                    leb_bytes_next = 4'd0;
                    raw_cnt_next   = 3'd0;
                    if (b == wcsp_pkg::OP_END) begin
                        emit = 1'b1;
                        if (cur_depth != '0) depth_after = cur_depth - 1'b1;
                        else res.expr_end = 1'b1;
                    end else if (b == wcsp_pkg::OP_ELSE) begin
                        emit = 1'b1;
                        if (else_ok) begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(cur_depth - 1'b1);
                        end else begin
                            res.error_code = wcsp_pkg::ERR_OPCODE;
                        end
                    end else if (wcsp_pkg::op_plain(b)) begin
                        emit = 1'b1;
                    end else if (wcsp_pkg::op_mode(b) == wcsp_pkg::MODE_OPCODE) begin
                        emit           = 1'b1;
                        res.error_code = wcsp_pkg::ERR_OPCODE;
                    end
                end
                wcsp_pkg::MODE_BTYPE: begin
                    emit = 1'b1;
                    if (!btype_ok) begin
                        res.error_code = wcsp_pkg::ERR_VALTYPE;
                    end else if (cur_depth >= DW'(MAX_DEPTH)) begin
                        res.error_code = wcsp_pkg::ERR_DEPTH;
                    end else begin
                        wr_en         = 1'b1;
                        wr_kind       = 2'(cur_pending - 8'd2);
                        depth_after   = cur_depth + 1'b1;
                        res.imm_kind  = wcsp_pkg::KIND_BTYPE;
                        res.immediate = {56'd0, b};
                    end
                end
                wcsp_pkg::MODE_CI_RES, wcsp_pkg::MODE_MEM_RES: begin
                    emit = 1'b1;
                    if (b != 8'd0) begin
                        res.error_code = wcsp_pkg::ERR_RESERVED;
                    end else if (cur_mode == wcsp_pkg::MODE_CI_RES) begin
                        res.imm_kind  = wcsp_pkg::KIND_INDEX;
                        res.immediate = {32'd0, cur_align};
                    end
                end
                wcsp_pkg::MODE_F32, wcsp_pkg::MODE_F64: begin
                    accum_next = cur_accum | ({56'd0, b} << {cur_raw, 3'b000});
                    if (cur_raw >= raw_last) begin
                        emit          = 1'b1;
                        res.imm_kind  = (cur_mode == wcsp_pkg::MODE_F32) ?
                                        wcsp_pkg::KIND_F32 : wcsp_pkg::KIND_F64;
                        res.immediate = accum_next;
                    end else begin
                        raw_cnt_next = cur_raw + 3'd1;
                    end
                end
                default: begin
                    // All LEB128 modes.
                    accum_next     = leb_accum;
                    leb_bytes_next = leb_bytes_out;
                    if (leb_status == wcsp_pkg::LEB_BAD) begin
                        emit           = 1'b1;
                        res.error_code = wcsp_pkg::ERR_LEB;
                    end else if (leb_status == wcsp_pkg::LEB_DONE) begin
                        case (cur_mode)
                            wcsp_pkg::MODE_INDEX: begin
                                emit          = 1'b1;
                                res.imm_kind  = wcsp_pkg::KIND_INDEX;
                                res.immediate = leb_accum;
                            end
                            wcsp_pkg::MODE_CI_IDX: begin
                                align_next = leb_accum[31:0];
                            end
                            wcsp_pkg::MODE_ALIGN: begin
                                align_next     = leb_accum[31:0];
                                accum_next     = 64'd0;
                                leb_bytes_next = 4'd0;
                                raw_cnt_next   = 3'd0;
                            end
                            wcsp_pkg::MODE_OFFSET: begin
                                emit           = 1'b1;
                                res.imm_kind   = wcsp_pkg::KIND_MEMARG;
                                res.immediate  = {32'd0, cur_align};
                                res.mem_offset = leb_accum[31:0];
                            end
                            wcsp_pkg::MODE_TCOUNT: begin
                                labels_next    = leb_accum[31:0];
                                accum_next     = 64'd0;
                                leb_bytes_next = 4'd0;
                                raw_cnt_next   = 3'd0;
                            end
                            wcsp_pkg::MODE_TLABEL: begin
                                emit           = 1'b1;
                                res.imm_kind   = wcsp_pkg::KIND_TLABEL;
                                res.immediate  = leb_accum;
                                labels_next    = labels_dec;
                                accum_next     = 64'd0;
                                leb_bytes_next = 4'd0;
                                raw_cnt_next   = 3'd0;
                            end
                            wcsp_pkg::MODE_TDEFAULT: begin
                                emit          = 1'b1;
                                res.imm_kind  = wcsp_pkg::KIND_TDEFAULT;
                                res.immediate = leb_accum;
                            end
                            wcsp_pkg::MODE_I32: begin
                                emit          = 1'b1;
                                res.imm_kind  = wcsp_pkg::KIND_I32;
                                res.immediate = leb_accum;
                            end
                            default: begin
                                emit          = 1'b1;
                                res.imm_kind  = wcsp_pkg::KIND_I64;
                                res.immediate = leb_accum;
                            end
                        endcase
                    end
                end
            endcase
            if (res.error_code != wcsp_pkg::ERR_OK) begin
                err_next = 1'b1;
                wr_en    = 1'b0;
            end
        end
        res.opcode_out = pending_next;
        res.nest_depth = 6'(depth_after);
        wr_en          = wr_en && accept;
    end

    assign depth_next = accept ? depth_after : depth_reg;
    assign rd_addr    = (depth_next == '0) ? '0 : AW'(depth_next - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= wcsp_pkg::MODE_OPCODE;
            accum_reg     <= 64'd0;
            leb_bytes_reg <= 4'd0;
            raw_cnt_reg   <= 3'd0;
            pending_reg   <= 8'd0;
            align_reg     <= 32'd0;
            labels_reg    <= 32'd0;
            depth_reg     <= '0;
            err_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg      <= mode_next;
                accum_reg     <= accum_next;
                leb_bytes_reg <= leb_bytes_next;
                raw_cnt_reg   <= raw_cnt_next;
                pending_reg   <= pending_next;
                align_reg     <= align_next;
                labels_reg    <= labels_next;
                err_reg       <= err_next;
            end
            depth_reg <= depth_next;
            if (accept && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The depth never grows past the configured stack size.
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(MAX_DEPTH))
        else $error("nesting depth beyond stack size");

    // The depth moves by at most one level per beat, or drops to zero on restart.
    a_depth_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (depth_reg == $past(depth_reg)) ||
                           (depth_reg == $past(depth_reg) + 1'b1) ||
                           (depth_reg == $past(depth_reg) - 1'b1) ||
                           (depth_reg == '0))
        else $error("depth jumped by more than one level");

    // An error result leaves the parser latched.
    a_err_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && emit && res.error_code != wcsp_pkg::ERR_OK) |=> err_reg)
        else $error("error result without latched error");

    // The end of an expression is only reported at depth zero without error.
    a_expr_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.expr_end) |->
            (m_data.nest_depth == 6'd0) && (m_data.error_code == wcsp_pkg::ERR_OK))
        else $error("expression end away from depth zero");

endmodule
`default_nettype wire

// ----- tb/tb_parser_checker.sv -----
// Checker for the code stream parser: decodes accepted input beats and compares result beats.
`timescale 1ns / 1ps
`default_nettype none
module tb_parser_checker #(
    parameter int MAX_DEPTH = wcsp_pkg::MAX_DEPTH_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire wcsp_pkg::in_beat_t  s_data,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire wcsp_pkg::out_beat_t m_data,
    output int                       fail_count,
    output int                       tokens_pending
);

    wcsp_pkg::mode_t mode;
    logic [63:0]     accum;
    int unsigned     nbytes;
    int unsigned     nraw;
    logic [7:0]      cur_op;
    logic [31:0]     align_hold;
    logic [31:0]     labels;
    int unsigned     depth;
    logic [1:0]      levels [MAX_DEPTH];
    logic            stuck;

    wcsp_pkg::out_beat_t token_q[$];

    function automatic void clear_state();
        mode = wcsp_pkg::MODE_OPCODE;
        accum = '0;
        nbytes = 0;
        nraw = 0;
        cur_op = '0;
        align_hold = '0;
        labels = '0;
        depth = 0;
        stuck = 1'b0;
    endfunction

    function automatic void push_token(logic [3:0] kind, logic [63:0] imm, logic [31:0] off,
                                       logic [2:0] err, logic fin);
        wcsp_pkg::out_beat_t t;
        t.opcode_out = cur_op;
        t.imm_kind   = kind;
        t.immediate  = imm;
        t.mem_offset = off;
        t.nest_depth = depth[5:0];
        t.error_code = err;
        t.expr_end   = fin;
        token_q.push_back(t);
        mode = wcsp_pkg::MODE_OPCODE;
    endfunction

    function automatic void raise_error(logic [2:0] err);
        stuck = 1'b1;
        push_token(wcsp_pkg::KIND_NONE, '0, '0, err, 1'b0);
    endfunction

    // Feeds one LEB128 byte; bits is 32 or 64.
    function automatic wcsp_pkg::leb_status_t leb_step(logic [7:0] b, int unsigned bits,
                                                       bit sgn);
        int unsigned nmax;
        int unsigned used;
        int unsigned sh;
        logic [63:0] pay;
        logic [63:0] hi;
        nmax = (bits + 6) / 7;
        pay = {57'd0, b[6:0]};
        if (nbytes >= nmax) return wcsp_pkg::LEB_BAD;
        accum |= pay << (7 * nbytes);
        if (nbytes == nmax - 1) begin
            used = bits - 7 * (nmax - 1);
            if (b[7]) return wcsp_pkg::LEB_BAD;
            if (sgn) begin
                hi = pay >> (used - 1);
                if (hi != 0 && hi != (64'h7f >> (used - 1))) return wcsp_pkg::LEB_BAD;
            end else if ((pay >> used) != 0) begin
                return wcsp_pkg::LEB_BAD;
            end
        end else if (b[7]) begin
            nbytes++;
            return wcsp_pkg::LEB_MORE;
        end
        sh = 7 * (nbytes + 1);
        if (sgn && sh < 64 && b[6]) accum |= ~64'd0 << sh;
        if (bits == 32) accum &= 64'hffff_ffff;
        return wcsp_pkg::LEB_DONE;
    endfunction

    function automatic void start_op(logic [7:0] b);
        cur_op = b;
        accum = '0;
        nbytes = 0;
        nraw = 0;
        if (b == wcsp_pkg::OP_END) begin
            if (depth > 0) begin
                depth--;
                push_token(wcsp_pkg::KIND_NONE, '0, '0, wcsp_pkg::ERR_OK, 1'b0);
            end else begin
                push_token(wcsp_pkg::KIND_NONE, '0, '0, wcsp_pkg::ERR_OK, 1'b1);
            end
        end else if (b == wcsp_pkg::OP_ELSE) begin
            if (depth > 0 && depth <= MAX_DEPTH && levels[depth-1] == wcsp_pkg::LVL_IF) begin
                levels[depth-1] = wcsp_pkg::LVL_ELSE;
                push_token(wcsp_pkg::KIND_NONE, '0, '0, wcsp_pkg::ERR_OK, 1'b0);
            end else begin
                raise_error(wcsp_pkg::ERR_OPCODE);
            end
        end else if (b == 8'h00 || b == 8'h01 || b == 8'h0F || b == 8'h1A || b == 8'h1B ||
                     (b >= 8'h45 && b <= 8'hBF)) begin
            push_token(wcsp_pkg::KIND_NONE, '0, '0, wcsp_pkg::ERR_OK, 1'b0);
        end else if (b >= 8'h02 && b <= 8'h04) mode = wcsp_pkg::MODE_BTYPE;
        else if (b == 8'h0C || b == 8'h0D || b == 8'h10 || (b >= 8'h20 && b <= 8'h24))
            mode = wcsp_pkg::MODE_INDEX;
        else if (b == 8'h0E) mode = wcsp_pkg::MODE_TCOUNT;
        else if (b == 8'h11) mode = wcsp_pkg::MODE_CI_IDX;
        else if (b >= 8'h28 && b <= 8'h3E) mode = wcsp_pkg::MODE_ALIGN;
        else if (b == 8'h3F || b == 8'h40) mode = wcsp_pkg::MODE_MEM_RES;
        else if (b == 8'h41) mode = wcsp_pkg::MODE_I32;
        else if (b == 8'h42) mode = wcsp_pkg::MODE_I64;
        else if (b == 8'h43) mode = wcsp_pkg::MODE_F32;
        else if (b == 8'h44) mode = wcsp_pkg::MODE_F64;
        else raise_error(wcsp_pkg::ERR_OPCODE);
    endfunction

    function automatic void decode_byte(wcsp_pkg::in_beat_t beat);
        logic [7:0] b;
        wcsp_pkg::leb_status_t r;
        int unsigned n;
        b = beat.in_byte;
        if (beat.restart) clear_state();
        if (stuck) return;
        case (mode)
            wcsp_pkg::MODE_BTYPE: begin
                if (b != wcsp_pkg::BT_EMPTY && (b < wcsp_pkg::BT_F64 || b > wcsp_pkg::BT_I32))
                    raise_error(wcsp_pkg::ERR_VALTYPE);
                else if (depth >= MAX_DEPTH) raise_error(wcsp_pkg::ERR_DEPTH);
                else begin
                    levels[depth] = 2'(cur_op - 8'h02);
                    depth++;
                    push_token(wcsp_pkg::KIND_BTYPE, {56'd0, b}, '0, wcsp_pkg::ERR_OK, 1'b0);
                end
            end
            wcsp_pkg::MODE_INDEX, wcsp_pkg::MODE_CI_IDX, wcsp_pkg::MODE_ALIGN,
            wcsp_pkg::MODE_OFFSET, wcsp_pkg::MODE_TCOUNT, wcsp_pkg::MODE_TLABEL,
            wcsp_pkg::MODE_TDEFAULT: begin
                r = leb_step(b, 32, 1'b0);
                if (r == wcsp_pkg::LEB_BAD) raise_error(wcsp_pkg::ERR_LEB);
                else if (r == wcsp_pkg::LEB_DONE) begin
                    case (mode)
                        wcsp_pkg::MODE_INDEX:
                            push_token(wcsp_pkg::KIND_INDEX, accum, '0, wcsp_pkg::ERR_OK, 1'b0);
                        wcsp_pkg::MODE_CI_IDX: begin
                            align_hold = accum[31:0];
                            mode = wcsp_pkg::MODE_CI_RES;
                        end
                        wcsp_pkg::MODE_ALIGN: begin
                            align_hold = accum[31:0];
                            accum = '0;
                            nbytes = 0;
                            mode = wcsp_pkg::MODE_OFFSET;
                        end
                        wcsp_pkg::MODE_OFFSET:
                            push_token(wcsp_pkg::KIND_MEMARG, {32'd0, align_hold}, accum[31:0],
                                       wcsp_pkg::ERR_OK, 1'b0);
                        wcsp_pkg::MODE_TCOUNT: begin
                            labels = accum[31:0];
                            accum = '0;
                            nbytes = 0;
                            mode = (labels != 0) ? wcsp_pkg::MODE_TLABEL :
                                                   wcsp_pkg::MODE_TDEFAULT;
                        end
                        wcsp_pkg::MODE_TLABEL: begin
                            push_token(wcsp_pkg::KIND_TLABEL, accum, '0, wcsp_pkg::ERR_OK, 1'b0);
                            labels--;
                            accum = '0;
                            nbytes = 0;
                            mode = (labels != 0) ? wcsp_pkg::MODE_TLABEL :
                                                   wcsp_pkg::MODE_TDEFAULT;
                        end
                        default:
                            push_token(wcsp_pkg::KIND_TDEFAULT, accum, '0, wcsp_pkg::ERR_OK,
                                       1'b0);
                    endcase
                end
            end
            wcsp_pkg::MODE_CI_RES: begin
                if (b != 0) raise_error(wcsp_pkg::ERR_RESERVED);
                else push_token(wcsp_pkg::KIND_INDEX, {32'd0, align_hold}, '0,
                                wcsp_pkg::ERR_OK, 1'b0);
            end
            wcsp_pkg::MODE_MEM_RES: begin
                if (b != 0) raise_error(wcsp_pkg::ERR_RESERVED);
                else push_token(wcsp_pkg::KIND_NONE, '0, '0, wcsp_pkg::ERR_OK, 1'b0);
            end
            wcsp_pkg::MODE_I32, wcsp_pkg::MODE_I64: begin
                r = leb_step(b, (mode == wcsp_pkg::MODE_I32) ? 32 : 64, 1'b1);
                if (r == wcsp_pkg::LEB_BAD) raise_error(wcsp_pkg::ERR_LEB);
                else if (r == wcsp_pkg::LEB_DONE)
                    push_token((mode == wcsp_pkg::MODE_I32) ? wcsp_pkg::KIND_I32 :
                               wcsp_pkg::KIND_I64, accum, '0, wcsp_pkg::ERR_OK, 1'b0);
            end
            wcsp_pkg::MODE_F32, wcsp_pkg::MODE_F64: begin
                n = (mode == wcsp_pkg::MODE_F32) ? 4 : 8;
                accum |= {56'd0, b} << (8 * (nraw % 8));
                if ((nraw % 8) + 1 >= n)
                    push_token((mode == wcsp_pkg::MODE_F32) ? wcsp_pkg::KIND_F32 :
                               wcsp_pkg::KIND_F64, accum, '0, wcsp_pkg::ERR_OK, 1'b0);
                else nraw = (nraw % 8) + 1;
            end
            default: begin
                mode = wcsp_pkg::MODE_OPCODE;
                start_op(b);
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        wcsp_pkg::out_beat_t want;
        if (!aresetn) begin
            clear_state();
            token_q.delete();
            fail_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (token_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = token_q.pop_front();
                    if (want !== m_data) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h actual %h", want, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) decode_byte(s_data);
        end
        tokens_pending = token_q.size();
    end
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Top of the testbench: clock, reset, byte stimulus, result backpressure and the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    wcsp_pkg::in_beat_t  s_data;
    logic                m_valid;
    logic                m_ready;
    wcsp_pkg::out_beat_t m_data;
    int                  fail_count;
    int                  tokens_pending;

    // Byte program built up front; the driver plays it out beat by beat.
    wcsp_pkg::in_beat_t byte_q[$];
    int        cycle_count;
    bit        calm;        // no idling in the closing stretch
    bit        hold_off;    // long receiver stall requested by the driver
    bit        sent_all;

    wasm_code_stream_parser dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    tb_parser_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .tokens_pending(tokens_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void put(logic [7:0] b, logic rs = 1'b0);
        wcsp_pkg::in_beat_t t;
        t.in_byte = b;
        t.restart = rs;
        byte_q.push_back(t);
    endfunction

    // Unsigned LEB128 of v; pad adds redundant continuation bytes.
    function automatic void put_uleb(logic [31:0] v, int pad = 0);
        int n;
        n = 0;
        do begin
            n++;
            if (v[31:7] != 0 || pad > 0) put({1'b1, v[6:0]});
            else put({1'b0, v[6:0]});
            v = v >> 7;
            if (v == 0 && pad > 0 && n < 5) pad--;
            else if (v == 0) pad = 0;
        end while ((v != 0 || pad > 0) && n < 5);
    endfunction

    // Signed LEB128 of v, minimal length.
    function automatic void put_sleb(logic signed [63:0] v);
        logic [6:0] g;
        bit done;
        done = 0;
        while (!done) begin
            g = v[6:0];
            v = v >>> 7;
            done = (v == 0 && !g[6]) || (v == -1 && g[6]);
            put({!done, g});
        end
    endfunction

    function automatic logic [31:0] rnd_u32();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 127);
            1: return $urandom_range(0, 20000);
            2: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // One instruction with random content, well-formed but for a possible stray else; depth kept by the caller.
    function automatic void put_instr(inout int d);
        int sel;
        logic [63:0] w;
        sel = $urandom_range(0, 15);
        case (sel)
            0: begin
                if (d < 31) begin
                    put(8'h02 + 8'($urandom_range(0, 2)));
                    put($urandom_range(0, 1) ? wcsp_pkg::BT_EMPTY :
                        8'h7C + 8'($urandom_range(0, 3)));
                    d++;
                end else put(8'h01);
            end
            1: if (d > 0) begin put(wcsp_pkg::OP_END); d--; end else put(8'h1A);
            2: begin put(8'h20 + 8'($urandom_range(0, 4))); put_uleb(rnd_u32()); end
            3: begin
                put(8'h28 + 8'($urandom_range(0, 22)));
                put_uleb($urandom_range(0, 3)); put_uleb(rnd_u32());
            end
            4: begin put(8'h41); w = {$urandom, $urandom}; put_sleb(64'(signed'(w[31:0]))); end
            5: begin
                put(8'h42); w = {$urandom, $urandom};
                put_sleb($signed(w >>> $urandom_range(0, 63)));
            end
            6: begin put(8'h43); repeat (4) put(8'($urandom)); end
            7: begin put(8'h44); repeat (8) put(8'($urandom)); end
            8: begin
                put(8'h0E); sel = $urandom_range(0, 3); put_uleb(sel);
                repeat (sel) put_uleb(rnd_u32()); put_uleb(rnd_u32());
            end
            9: begin put(8'h11); put_uleb(rnd_u32()); put(8'h00); end
            10: begin put(8'h3F + 8'($urandom_range(0, 1))); put(8'h00); end
            11: begin
                put(8'h0C + 8'($urandom_range(0, 1)));
                put_uleb(rnd_u32(), $urandom_range(0, 2));
            end
            12: begin put(8'h10); put_uleb(rnd_u32()); end
            13: put(wcsp_pkg::OP_ELSE);   // may be legal or not; the checker decides
            default: put(8'h45 + 8'($urandom_range(0, 8'hBF - 8'h45)));
        endcase
    endfunction

    task automatic build_program();
        int d;
        // Directed part: extremes, nesting, each special case.
        put(8'h41, 1'b1); put(8'hff); put(8'hff); put(8'hff); put(8'hff); put(8'h07);
        put(8'h41); put(8'h80); put(8'h80); put(8'h80); put(8'h80); put(8'h78);
        put(8'h42); repeat (9) put(8'hff); put(8'h7f);
        put(8'h04); put(8'h7f); put(wcsp_pkg::OP_ELSE); put(wcsp_pkg::OP_ELSE); // second else errors
        put(8'h0E, 1'b1); put(8'h00); put(8'h05);                  // empty label table
        put(8'h11); put(8'h03); put(8'h00);
        put(8'h3F); put(8'h00); put(8'h40); put(8'h01);            // reserved byte nonzero
        put(8'h10, 1'b1); put(8'hff); put(8'hff); put(8'hff); put(8'hff); put(8'h1f);
        put(8'h02, 1'b1); put(8'h7b);                              // bad value type
        put(8'hff, 1'b1);                                          // unknown opcode
        put(8'h41, 1'b1); put(8'h80); put(8'h80); put(8'h80); put(8'h80); put(8'h80);
        put(wcsp_pkg::OP_END, 1'b1); put(8'h00);
        // Too deep: 33 blocks open in a row.
        put(8'h03, 1'b1); put(wcsp_pkg::BT_EMPTY);
        repeat (32) begin put(8'h02); put(wcsp_pkg::BT_I32); end
        // Random part: mostly well-formed expressions, some noise and broken ones.
        d = 0;
        put(8'h01, 1'b1);
        while (byte_q.size() < 1150) begin
            if ($urandom_range(0, 19) == 0) begin
                put(8'($urandom), 1'b1); d = 0;
            end else if ($urandom_range(0, 29) == 0) begin
                put(8'($urandom)); // noise within a sequence
            end else if ($urandom_range(0, 24) == 0) begin
                while (d > 0) begin put(wcsp_pkg::OP_END); d--; end
                put(wcsp_pkg::OP_END);
            end else put_instr(d);
        end
    endtask

    // Sender: offers the program, with random bursts of idle cycles.
    initial begin
        int gap;
        s_valid <= 1'b0;
        s_data <= '0;
        aresetn <= 1'b0;
        calm = 0; hold_off = 0; sent_all = 0;
        build_program();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < byte_q.size(); i++) begin
            if (i == 300) hold_off = 1;
            if (i > byte_q.size() - 150) calm = 1;
            if (!calm && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data <= byte_q[i];
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
        end
        s_valid <= 1'b0;
        sent_all = 1;
    end

    // Receiver: random stalls, plus one long hold-off so the parser backs up.
    initial begin
        int gap;
        bit held;
        held = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_off && !held) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Cycle limit and end of run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 200000) begin
                $display("tb: failure");
                $finish;
            end
            if (sent_all && tokens_pending == 0) begin
                repeat (20) @(posedge aclk);
                if (fail_count == 0 && tokens_pending == 0) begin
                    $display("tb: success");
                end else begin
                    $display("tb: failure");
                end
                $finish;
            end
        end
    end
endmodule
`default_nettype wire
